// ===== src/assert_macros.svh =====
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SHA_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

`define SHA_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define SHA_ASSERT(label, prop)

`define SHA_ASSERT_NEVER(label, cond)

`endif

`endif

// ===== src/sha_pkg.sv =====
package sha_pkg;

	// Eight 32-bit words, index 0 is word a.
	typedef logic [7:0][31:0] sha_state_t;

	// Sixteen-word message schedule window, index 0 is the oldest word.
	typedef logic [15:0][31:0] sha_window_t;

	typedef struct packed {
		logic push;   // shift one message word into the schedule window
		logic start;  // load working variables and begin the rounds
	} sha_ctl_t;

	typedef struct packed {
		logic busy;   // rounds in progress
		logic done;   // sum output holds the updated chaining value
	} sha_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPRESS,
		ST_EMIT
	} sha_state_e_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] CFG_USE_STD_IV = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CUSTOM_AB  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_CUSTOM_CD  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_CUSTOM_EF  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_CUSTOM_GH  = 3'd4;

	localparam logic [3:0] LAST_WORD_OF_BLOCK = 4'd15;
	localparam logic [5:0] LAST_ROUND         = 6'd63;
	localparam logic [2:0] LAST_DIGEST_WORD   = 3'd7;

	localparam logic [31:0] STD_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
			input logic [31:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c);
		return (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== src/sha_if.sv =====
interface sha_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] message_word;
	logic        message_end;

	modport source (output valid, output message_word, output message_end, input ready);
	modport sink (input valid, input message_word, input message_end, output ready);
endinterface

interface sha_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// ===== src/sha_compress.sv =====
module sha_compress
	import sha_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  sha_ctl_t   ctl,
	input  logic [31:0] word,
	input  sha_state_t chain_in,
	output sha_state_t sum,
	output sha_stat_t  stat
);

	sha_window_t win_q;
	sha_state_t  v_q;
	sha_state_t  v_next;
	logic [5:0]  round_q;
	logic        running_q;
	logic        done_q;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;

	// Next schedule word from the sliding window.
	assign w_new = win_q[0] + small_sigma0(win_q[1]) + win_q[9] + small_sigma1(win_q[14]);

	// One compression round; a single round unit, reused for all 64 rounds.
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + choose(v_q[4], v_q[5], v_q[6])
		+ ROUND_K[round_q] + win_q[0];
	assign t2 = big_sigma0(v_q[0]) + majority(v_q[0], v_q[1], v_q[2]);

	always_comb begin
		v_next[0] = t1 + t2;
		v_next[1] = v_q[0];
		v_next[2] = v_q[1];
		v_next[3] = v_q[2];
		v_next[4] = v_q[3] + t1;
		v_next[5] = v_q[4];
		v_next[6] = v_q[5];
		v_next[7] = v_q[6];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q   <= '0;
			running_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				round_q   <= '0;
				running_q <= 1'b1;
			end else if (running_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == LAST_ROUND) begin
					running_q <= 1'b0;
					done_q    <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_q <= {word, win_q[15:1]};
		end else if (running_q) begin
			win_q <= {w_new, win_q[15:1]};
		end
		if (ctl.start) begin
			v_q <= chain_in;
		end else if (running_q) begin
			v_q <= v_next;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			sum[i] = chain_in[i] + v_q[i];
		end
	end

	assign stat.busy = running_q;
	assign stat.done = done_q;

endmodule

// ===== src/sha256_block_hasher.sv =====
// SHA-256 over an already padded message. Send the message one 32-bit big-endian word per
// request on word_ch, sixteen words to a block, and flag the final word of the message with
// message_end. Words of a block are taken one per cycle; after the sixteenth the block runs
// the 64 rounds through a single round unit, one round a cycle, and then folds the result
// into the chaining value; word_ch holds ready low while the rounds run. After the word
// flagged message_end the block returns the eight digest words, a first, on digest_ch, one
// per request, with last_word set on the eighth; word_ch stays low until all eight are
// taken. A message_end on a word that does not close a block drops that partial block and
// returns the digest of the blocks finished so far. The chaining value is loaded on the first
// word of each message from the standard initial value or, with use_std_iv cleared, from
// the four custom registers (upper half of each register is the earlier word). Write
// configuration only while the block is idle; a write to an index past the last register
// is ignored.
`include "assert_macros.svh"

module sha256_block_hasher
	import sha_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	sha_word_if.sink               word_ch,
	sha_digest_if.source           digest_ch
);

	sha_state_e_t state_q;
	sha_state_e_t state_next;

	// Configuration registers
	logic             use_std_iv_q;
	logic [3:0][63:0] custom_iv_q;

	// Message progress
	logic [3:0] word_cnt_q;
	logic       started_q;
	logic       end_pend_q;
	logic [2:0] idx_q;

	sha_state_t chain_q;
	sha_state_t iv_sel;
	sha_state_t sum;
	sha_ctl_t   ctl;
	sha_stat_t  stat;

	logic in_fire;
	logic out_fire;

	assign in_fire  = word_ch.valid && word_ch.ready;
	assign out_fire = digest_ch.valid && digest_ch.ready;

	// Configuration writes; unknown indexes fall through and are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_std_iv_q <= 1'b1;
			custom_iv_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_USE_STD_IV: use_std_iv_q   <= cfg_data[0];
				CFG_CUSTOM_AB:  custom_iv_q[0] <= cfg_data;
				CFG_CUSTOM_CD:  custom_iv_q[1] <= cfg_data;
				CFG_CUSTOM_EF:  custom_iv_q[2] <= cfg_data;
				CFG_CUSTOM_GH:  custom_iv_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Initial chaining value picked by the current configuration.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			iv_sel[2*i]   = use_std_iv_q ? STD_IV[2*i]   : custom_iv_q[i][63:32];
			iv_sel[2*i+1] = use_std_iv_q ? STD_IV[2*i+1] : custom_iv_q[i][31:0];
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (word_cnt_q == LAST_WORD_OF_BLOCK) begin
						state_next = ST_COMPRESS;
					end else if (word_ch.message_end) begin
						state_next = ST_EMIT;
					end
				end
			end
			ST_COMPRESS: begin
				if (stat.done) begin
					state_next = end_pend_q ? ST_EMIT : ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (out_fire && idx_q == LAST_DIGEST_WORD) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		word_ch.ready   = (state_q == ST_IDLE);
		digest_ch.valid = (state_q == ST_EMIT);
		ctl.push        = in_fire;
		ctl.start       = in_fire && (word_cnt_q == LAST_WORD_OF_BLOCK);
	end

	// Digest words come straight from the chaining value.
	assign digest_ch.digest_word = chain_q[idx_q];
	assign digest_ch.word_index  = idx_q;
	assign digest_ch.last_word   = (idx_q == LAST_DIGEST_WORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			word_cnt_q <= '0;
			started_q  <= 1'b0;
			end_pend_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			state_q <= state_next;
			if (in_fire) begin
				started_q  <= 1'b1;
				end_pend_q <= word_ch.message_end;
				// Drop any partial block at message end.
				word_cnt_q <= word_ch.message_end ? 4'd0 : word_cnt_q + 4'd1;
			end
			if (out_fire) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == LAST_DIGEST_WORD) begin
					started_q <= 1'b0;
				end
			end
		end
	end

	// Chaining value: load the selected IV on a message's first word, fold in each block.
	always_ff @(posedge clk) begin
		if (in_fire && !started_q) begin
			chain_q <= iv_sel;
		end else if (stat.done) begin
			chain_q <= sum;
		end
	end

	sha_compress u_compress (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.word     (word_ch.message_word),
		.chain_in (chain_q),
		.sum      (sum),
		.stat     (stat)
	);

	`SHA_ASSERT(a_rounds_only_in_compress, (stat.busy || stat.done) |-> state_q == ST_COMPRESS)
	`SHA_ASSERT(a_full_block_compresses, ctl.start |=> (state_q == ST_COMPRESS && stat.busy))
	`SHA_ASSERT(a_last_digest_ends_msg, (out_fire && digest_ch.last_word) |=> (!started_q && state_q == ST_IDLE && idx_q == 3'd0))
	`SHA_ASSERT_NEVER(a_no_start_without_msg, ctl.start && !started_q)

endmodule
